[rtl/dfa_word_count_mod_prime_unit_assert.svh]
// Assertion macros shared by the word count block.
`ifndef DFA_WORD_COUNT_MOD_PRIME_UNIT_ASSERT_SVH
`define DFA_WORD_COUNT_MOD_PRIME_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dwc_pkg.sv]
// Types, constants and the modular add of the automaton word counter.
package dwc_pkg;

    localparam int NUM_STATES  = 128;
    localparam int NUM_LETTERS = 26;

    localparam int STATE_W  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int LETTER_W = (NUM_LETTERS > 1) ? $clog2(NUM_LETTERS) : 1;

    // Fixed field widths of the channels
    localparam int STATE_FLD_W  = 7;
    localparam int LETTER_FLD_W = 5;
    localparam int OPCODE_W     = 2;
    localparam int COUNT_W      = 30;
    localparam int LEN_W        = 20;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 20;

    typedef logic [STATE_W-1:0]          t_state;
    typedef logic [LETTER_W-1:0]         t_letter;
    typedef logic [STATE_W+LETTER_W-1:0] t_taddr;
    typedef logic [STATE_W:0]            t_caddr;
    typedef logic [COUNT_W-1:0]          t_count;
    typedef logic [LEN_W-1:0]            t_len;
    typedef logic [STATE_FLD_W-1:0]      t_state_fld;
    typedef logic [LETTER_FLD_W-1:0]     t_letter_fld;
    typedef logic [OPCODE_W-1:0]         t_opcode;
    typedef logic [CFG_IDX_W-1:0]        t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]       t_cfg_data;

    typedef struct packed {
        logic   valid;
        t_state target;
    } t_trans;

    localparam t_opcode OP_LOAD  = 2'd0;
    localparam t_opcode OP_MARK  = 2'd1;
    localparam t_opcode OP_COUNT = 2'd2;

    localparam t_cfg_idx CFG_WORD_LENGTH = 1'd0;
    localparam t_cfg_idx CFG_START_STATE = 1'd1;

    localparam t_count MODULUS = 30'd1000000007;

    localparam t_state_fld START_STATE_RESET = 7'd1;

    // Both operands are below the modulus, so one conditional subtract suffices
    function automatic t_count add_mod(input t_count a, input t_count b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage

[rtl/dwc_channels.sv]
// Valid/ready channel interfaces: input items, results and register writes.
interface dwc_item_if;
    logic                 valid;
    logic                 ready;
    dwc_pkg::t_opcode     opcode;
    dwc_pkg::t_state_fld  from_state;
    dwc_pkg::t_letter_fld letter;
    dwc_pkg::t_state_fld  to_state;

    modport source (output valid, output opcode, output from_state, output letter,
                    output to_state, input ready);
    modport sink (input valid, input opcode, input from_state, input letter,
                  input to_state, output ready);
endinterface

interface dwc_result_if;
    logic            valid;
    logic            ready;
    dwc_pkg::t_count word_count;

    modport source (output valid, output word_count, input ready);
    modport sink (input valid, input word_count, output ready);
endinterface

interface dwc_cfg_if;
    logic               valid;
    logic               ready;
    dwc_pkg::t_cfg_idx  index;
    dwc_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/dfa_word_count_mod_prime_unit.sv]
// Top level of the automaton word counter: sequencer, tables and modular adder.
// Usage: three valid/ready channels. i_in takes items: a load stores one transition
// (from_state, letter -> to_state), a mark flags from_state as accepting, a count
// runs the counting pass and returns one result on o_out. i_cfg writes word_length
// (index 0) and start_state (index 1) and is always ready.
// Load and mark items complete as they are taken. A count initialises the counts,
// runs L rounds (L = word_length), each clearing the other bank and propagating
// every nonzero state count along its valid edges, then sums the accepting states.
// The count memory and the single modular adder are shared by every edge update,
// each edge costing a transition read, a count read and a write; a state with
// zero count is skipped after one read.
// At reset a pass clears all 4096 transition table entries, one entry a cycle;
// i_in is not ready during the pass and during a count. Accepting flags clear at
// once, word_length resets to 0 and start_state to 1.
// The result sits in an output register: a stalled receiver holds it, and load
// and mark items are still taken meanwhile; a following count finishes its work
// and waits for the register to free up before it delivers.
`include "dfa_word_count_mod_prime_unit_assert.svh"

module dfa_word_count_mod_prime_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dwc_item_if.sink      i_in,
    dwc_result_if.source  o_out,
    dwc_cfg_if.sink       i_cfg
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_INIT  = 12'b0000_0000_0100,
        S_RCLR  = 12'b0000_0000_1000,
        S_SRC   = 12'b0000_0001_0000,
        S_CHK   = 12'b0000_0010_0000,
        S_TRD   = 12'b0000_0100_0000,
        S_TCHK  = 12'b0000_1000_0000,
        S_ADD   = 12'b0001_0000_0000,
        S_SUM   = 12'b0010_0000_0000,
        S_SUMA  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_fsm;

    t_fsm                            r_state, n_state;
    dwc_pkg::t_state                 r_st, n_st;
    dwc_pkg::t_letter                r_let, n_let;
    dwc_pkg::t_len                   r_round, n_round;
    logic                            r_bank, n_bank;
    dwc_pkg::t_taddr                 r_clr;
    logic [dwc_pkg::NUM_STATES-1:0]  r_accept;
    dwc_pkg::t_len                   r_word_length;
    dwc_pkg::t_state_fld             r_start_state;
    logic                            r_out_valid;
    dwc_pkg::t_count                 r_word_count;
    dwc_pkg::t_count                 r_c, n_c;
    dwc_pkg::t_state                 r_tgt, n_tgt;
    dwc_pkg::t_count                 r_total, n_total;

    // Transition table and path count banks
    dwc_pkg::t_trans                 r_tr_mem [2**(dwc_pkg::STATE_W+dwc_pkg::LETTER_W)];
    dwc_pkg::t_trans                 r_tr_q;
    dwc_pkg::t_count                 r_cnt_mem [2**(dwc_pkg::STATE_W+1)];
    dwc_pkg::t_count                 r_cnt_q;

    logic                            tr_we;
    dwc_pkg::t_taddr                 tr_waddr;
    dwc_pkg::t_trans                 tr_wdata;
    dwc_pkg::t_taddr                 tr_raddr;
    logic                            cnt_we;
    dwc_pkg::t_caddr                 cnt_waddr;
    dwc_pkg::t_count                 cnt_wdata;
    dwc_pkg::t_caddr                 cnt_raddr;

    logic                            in_xfer;
    logic                            load_ok;
    logic                            st_last;
    logic                            let_last;
    logic                            out_free;
    dwc_pkg::t_count                 add_b;
    dwc_pkg::t_count                 add_sum;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign st_last  = (r_st == dwc_pkg::t_state'(dwc_pkg::NUM_STATES - 1));
    assign let_last = (r_let == dwc_pkg::t_letter'(dwc_pkg::NUM_LETTERS - 1));
    assign out_free = !r_out_valid || o_out.ready;
    assign load_ok  = (32'(i_in.from_state) < dwc_pkg::NUM_STATES)
                   && (32'(i_in.to_state) < dwc_pkg::NUM_STATES)
                   && (32'(i_in.letter) < dwc_pkg::NUM_LETTERS);

    // Single modular adder: edge updates, or the running total while summing
    assign add_b   = (r_state == S_SUMA) ? r_total : r_c;
    assign add_sum = dwc_pkg::add_mod(r_cnt_q, add_b);

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.word_count = r_word_count;

    // Transition table port: clearing pass or load transfer
    always_comb begin
        tr_we    = 1'b0;
        tr_waddr = r_clr;
        tr_wdata = '0;
        if (r_state == S_CLEAR) begin
            tr_we = 1'b1;
        end else if (in_xfer && (i_in.opcode == dwc_pkg::OP_LOAD) && load_ok) begin
            tr_we    = 1'b1;
            tr_waddr = {dwc_pkg::t_state'(i_in.from_state), dwc_pkg::t_letter'(i_in.letter)};
            tr_wdata = '{valid: 1'b1, target: dwc_pkg::t_state'(i_in.to_state)};
        end
    end

    assign tr_raddr = {r_st, r_let};

    always_ff @(posedge i_clk) begin
        if (tr_we) begin
            r_tr_mem[tr_waddr] <= tr_wdata;
        end
        r_tr_q <= r_tr_mem[tr_raddr];
    end

    // Count memory ports: low seven bits of the address are the state, top bit the bank
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = {r_bank, r_st};
        cnt_wdata = '0;
        cnt_raddr = {r_bank, r_st};
        case (r_state)
            S_INIT: begin
                cnt_we    = 1'b1;
                cnt_wdata = (32'(r_start_state) == 32'(r_st)) ? dwc_pkg::t_count'(1) : '0;
            end
            S_RCLR: begin
                cnt_we    = 1'b1;
                cnt_waddr = {~r_bank, r_st};
            end
            S_TCHK: begin
                cnt_raddr = {~r_bank, r_tr_q.target};
            end
            S_ADD: begin
                cnt_we    = 1'b1;
                cnt_waddr = {~r_bank, r_tgt};
                cnt_wdata = add_sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= r_cnt_mem[cnt_raddr];
    end

    // Sequencer
    always_comb begin
        logic step_let;
        logic step_st;
        n_state  = r_state;
        n_st     = r_st;
        n_let    = r_let;
        n_round  = r_round;
        n_bank   = r_bank;
        n_c      = r_c;
        n_tgt    = r_tgt;
        n_total  = r_total;
        step_let = 1'b0;
        step_st  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer && (i_in.opcode == dwc_pkg::OP_COUNT)) begin
                    n_state = S_INIT;
                    n_st    = '0;
                    n_bank  = 1'b0;
                end
            end
            S_INIT: begin
                if (st_last) begin
                    n_st    = '0;
                    n_round = '0;
                    if (r_word_length == '0) begin
                        n_state = S_SUM;
                        n_total = '0;
                    end else begin
                        n_state = S_RCLR;
                    end
                end else begin
                    n_st = r_st + 1'b1;
                end
            end
            S_RCLR: begin
                if (st_last) begin
                    n_st    = '0;
                    n_state = S_SRC;
                end else begin
                    n_st = r_st + 1'b1;
                end
            end
            S_SRC: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_c = r_cnt_q;
                if (r_cnt_q == '0) begin
                    step_st = 1'b1;
                end else begin
                    n_let   = '0;
                    n_state = S_TRD;
                end
            end
            S_TRD: begin
                n_state = S_TCHK;
            end
            S_TCHK: begin
                if (r_tr_q.valid) begin
                    n_tgt   = r_tr_q.target;
                    n_state = S_ADD;
                end else begin
                    step_let = 1'b1;
                end
            end
            S_ADD: begin
                step_let = 1'b1;
            end
            S_SUM: begin
                n_state = S_SUMA;
            end
            S_SUMA: begin
                if (r_accept[r_st]) begin
                    n_total = add_sum;
                end
                if (st_last) begin
                    n_state = S_DONE;
                end else begin
                    n_st    = r_st + 1'b1;
                    n_state = S_SUM;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance to the next letter, then to the next state, then to the next round
        if (step_let) begin
            if (let_last) begin
                step_st = 1'b1;
            end else begin
                n_let   = r_let + 1'b1;
                n_state = S_TRD;
            end
        end
        if (step_st) begin
            if (st_last) begin
                n_st    = '0;
                n_bank  = ~r_bank;
                n_round = r_round + 1'b1;
                if (n_round == r_word_length) begin
                    n_state = S_SUM;
                    n_total = '0;
                end else begin
                    n_state = S_RCLR;
                end
            end else begin
                n_st    = r_st + 1'b1;
                n_state = S_SRC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_st          <= '0;
            r_let         <= '0;
            r_round       <= '0;
            r_bank        <= 1'b0;
            r_clr         <= '0;
            r_accept      <= '0;
            r_word_length <= '0;
            r_start_state <= dwc_pkg::START_STATE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_let   <= n_let;
            r_round <= n_round;
            r_bank  <= n_bank;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (in_xfer && (i_in.opcode == dwc_pkg::OP_MARK)
                    && (32'(i_in.from_state) < dwc_pkg::NUM_STATES)) begin
                r_accept[dwc_pkg::t_state'(i_in.from_state)] <= 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    dwc_pkg::CFG_WORD_LENGTH: r_word_length <= i_cfg.data[dwc_pkg::LEN_W-1:0];
                    dwc_pkg::CFG_START_STATE: begin
                        r_start_state <= i_cfg.data[dwc_pkg::STATE_FLD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_tgt   <= n_tgt;
        r_total <= n_total;
        if ((r_state == S_DONE) && out_free) begin
            r_word_count <= r_total;
        end
    end

    `DWC_ASSERT_NOW(a_result_reduced, i_clk, i_rst_n, o_out.valid, o_out.word_count < dwc_pkg::MODULUS, "result not reduced modulo prime")
    `DWC_ASSERT_NOW(a_edge_sum_reduced, i_clk, i_rst_n, r_state == S_ADD, cnt_wdata < dwc_pkg::MODULUS, "edge update not reduced modulo prime")
    `DWC_ASSERT_NOW(a_round_in_range, i_clk, i_rst_n, r_state == S_SRC, r_round < r_word_length, "propagation past the last round")
    `DWC_ASSERT_NEXT(a_count_starts, i_clk, i_rst_n, in_xfer && (i_in.opcode == dwc_pkg::OP_COUNT), r_state == S_INIT, "count transfer did not start the pass")

endmodule

[dv/tb_dfa_word_count_mod_prime_unit.sv]
// Self-checking testbench for the automaton word counter: directed and random items.
module tb_dfa_word_count_mod_prime_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam dwc_pkg::t_opcode OP_UNUSED       = 2'd3;
    localparam int               RANDOM_PHASES   = 8;
    localparam int               ITEMS_PER_PHASE = 22;
    localparam int               SETTLE_CYCLES   = 16;
    localparam int               TAIL_CYCLES     = 64;
    localparam int               WATCHDOG_LIMIT  = 2000000;

    typedef struct {
        dwc_pkg::t_opcode     op;
        dwc_pkg::t_state_fld  src;
        dwc_pkg::t_letter_fld letter;
        dwc_pkg::t_state_fld  dst;
    } t_dfa_item;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    dwc_item_if   item_ch ();
    dwc_result_if result_ch ();
    dwc_cfg_if    cfg_ch ();

    dfa_word_count_mod_prime_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of the automaton and the registers
    bit                  trans_ok  [dwc_pkg::NUM_STATES][dwc_pkg::NUM_LETTERS];
    dwc_pkg::t_state_fld trans_dst [dwc_pkg::NUM_STATES][dwc_pkg::NUM_LETTERS];
    bit                  accept_flag [dwc_pkg::NUM_STATES];
    dwc_pkg::t_len       len_reg;
    dwc_pkg::t_state_fld start_reg;

    t_dfa_item       pending_items [$];
    dwc_pkg::t_count expected_counts [$];
    int              mismatch_count;

    t_dfa_item cur_item;
    int        burst_left;
    int        gap_left;

    t_rx_mode  rx_mode;
    int        rx_cycle;
    int        quiet_cycles;

    function automatic dwc_pkg::t_count mod_add(dwc_pkg::t_count a, dwc_pkg::t_count b);
        logic [dwc_pkg::COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, dwc_pkg::MODULUS}) begin
            s -= {1'b0, dwc_pkg::MODULUS};
        end
        return s[dwc_pkg::COUNT_W-1:0];
    endfunction

    function automatic dwc_pkg::t_count count_accepted_words();
        dwc_pkg::t_count paths [2][dwc_pkg::NUM_STATES];
        dwc_pkg::t_count c;
        dwc_pkg::t_count total;
        int              bank;
        bank  = 0;
        total = '0;
        for (int s = 0; s < dwc_pkg::NUM_STATES; s++) begin
            paths[0][s] = '0;
        end
        if (start_reg < dwc_pkg::NUM_STATES) begin
            paths[0][start_reg] = dwc_pkg::t_count'(1);
        end
        for (int r = 0; r < len_reg; r++) begin
            for (int s = 0; s < dwc_pkg::NUM_STATES; s++) begin
                paths[bank ^ 1][s] = '0;
            end
            for (int s = 0; s < dwc_pkg::NUM_STATES; s++) begin
                c = paths[bank][s];
                if (c != 0) begin
                    for (int l = 0; l < dwc_pkg::NUM_LETTERS; l++) begin
                        if (trans_ok[s][l]) begin
                            paths[bank ^ 1][trans_dst[s][l]] =
                                mod_add(paths[bank ^ 1][trans_dst[s][l]], c);
                        end
                    end
                end
            end
            bank ^= 1;
        end
        for (int s = 0; s < dwc_pkg::NUM_STATES; s++) begin
            if (accept_flag[s]) begin
                total = mod_add(total, paths[bank][s]);
            end
        end
        return total;
    endfunction

    function automatic void apply_item(t_dfa_item it);
        case (it.op)
            dwc_pkg::OP_LOAD: begin
                if (it.src < dwc_pkg::NUM_STATES && it.dst < dwc_pkg::NUM_STATES
                        && it.letter < dwc_pkg::NUM_LETTERS) begin
                    trans_ok[it.src][it.letter]  = 1'b1;
                    trans_dst[it.src][it.letter] = it.dst;
                end
            end
            dwc_pkg::OP_MARK: begin
                if (it.src < dwc_pkg::NUM_STATES) begin
                    accept_flag[it.src] = 1'b1;
                end
            end
            dwc_pkg::OP_COUNT: expected_counts.push_back(count_accepted_words());
            default: ;
        endcase
    endfunction

    task automatic push_item(dwc_pkg::t_opcode op, int src, int letter, int dst);
        t_dfa_item it;
        it.op     = op;
        it.src    = dwc_pkg::t_state_fld'(src);
        it.letter = dwc_pkg::t_letter_fld'(letter);
        it.dst    = dwc_pkg::t_state_fld'(dst);
        pending_items.push_back(it);
    endtask

    task automatic write_reg(dwc_pkg::t_cfg_idx idx, dwc_pkg::t_cfg_data val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == dwc_pkg::CFG_WORD_LENGTH) begin
            len_reg = val[dwc_pkg::LEN_W-1:0];
        end else if (idx == dwc_pkg::CFG_START_STATE) begin
            start_reg = val[dwc_pkg::STATE_FLD_W-1:0];
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold until every item is taken and every count has come back, then settle
    task automatic wait_idle();
        while (pending_items.size() > 0 || item_ch.valid || expected_counts.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random_items(int n);
        int               sel;
        bit               near;
        dwc_pkg::t_opcode op;
        int               src;
        int               dst;
        int               letter;
        for (int k = 0; k < n; k++) begin
            sel    = $urandom_range(0, 99);
            near   = $urandom_range(0, 99) < 85;
            src    = near ? $urandom_range(0, 15) : $urandom_range(0, 127);
            dst    = near ? $urandom_range(0, 15) : $urandom_range(0, 127);
            letter = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25);
            if (sel < 55) begin
                op = dwc_pkg::OP_LOAD;
            end else if (sel < 70) begin
                op = dwc_pkg::OP_MARK;
            end else if (sel < 90) begin
                op     = dwc_pkg::OP_COUNT;
                src    = $urandom_range(0, 127);
                dst    = $urandom_range(0, 127);
                letter = $urandom_range(0, 31);
            end else begin
                op = OP_UNUSED;
            end
            push_item(op, src, letter, dst);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                apply_item(cur_item);
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    item_ch.valid      <= 1'b1;
                    item_ch.opcode     <= cur_item.op;
                    item_ch.from_state <= cur_item.src;
                    item_ch.letter     <= cur_item.letter;
                    item_ch.to_state   <= cur_item.dst;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver, result check and watchdog
    always @(posedge i_clk) begin
        logic            rdy;
        dwc_pkg::t_count want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            quiet_cycles = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected word_count result, got %0d", $time,
                             result_ch.word_count);
                    mismatch_count++;
                end else begin
                    want = expected_counts.pop_front();
                    if (result_ch.word_count !== want) begin
                        $display("%0t: word_count mismatch, expected %0d, got %0d", $time,
                                 want, result_ch.word_count);
                        mismatch_count++;
                    end
                end
            end
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (rx_cycle % 64 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            end
            rx_cycle++;
            case (rx_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = (rx_cycle % 7 == 0);
                default:   rdy = 1'b0;
            endcase
            result_ch.ready <= rdy;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int                 pick;
        int                 st;
        dwc_pkg::t_cfg_data start_val;

        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = dwc_pkg::CFG_WORD_LENGTH;
        cfg_ch.data  = '0;

        for (int s = 0; s < dwc_pkg::NUM_STATES; s++) begin
            accept_flag[s] = 1'b0;
            for (int l = 0; l < dwc_pkg::NUM_LETTERS; l++) begin
                trans_ok[s][l]  = 1'b0;
                trans_dst[s][l] = '0;
            end
        end
        len_reg        = '0;
        start_reg      = dwc_pkg::START_STATE_RESET;
        mismatch_count = 0;
        burst_left     = 1;
        gap_left       = 0;
        rx_mode        = RX_OPEN;
        rx_cycle       = 0;
        quiet_cycles   = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: zero length from start state 1, before and after it is marked accepting
        push_item(dwc_pkg::OP_COUNT, 127, 31, 127);
        push_item(dwc_pkg::OP_MARK, 1, 0, 0);
        push_item(dwc_pkg::OP_COUNT, 0, 0, 0);
        push_item(dwc_pkg::OP_MARK, 1, 31, 127);
        push_item(OP_UNUSED, 127, 31, 127);
        push_item(dwc_pkg::OP_LOAD, 127, 31, 127);
        push_item(dwc_pkg::OP_LOAD, 127, 26, 0);
        wait_idle();

        // Two self loops over 31 rounds wrap past the modulus; then overwrite one
        write_reg(dwc_pkg::CFG_WORD_LENGTH, 20'd31);
        write_reg(dwc_pkg::CFG_START_STATE, 20'hFFF80);
        push_item(dwc_pkg::OP_LOAD, 0, 0, 0);
        push_item(dwc_pkg::OP_LOAD, 0, 25, 0);
        push_item(dwc_pkg::OP_MARK, 0, 0, 0);
        push_item(dwc_pkg::OP_COUNT, 0, 0, 0);
        push_item(dwc_pkg::OP_LOAD, 0, 25, 127);
        push_item(dwc_pkg::OP_LOAD, 127, 0, 0);
        push_item(dwc_pkg::OP_MARK, 127, 0, 0);
        push_item(dwc_pkg::OP_COUNT, 127, 25, 0);
        wait_idle();

        write_reg(dwc_pkg::CFG_WORD_LENGTH, '0);
        write_reg(dwc_pkg::CFG_START_STATE, 20'h0007F);
        push_item(dwc_pkg::OP_COUNT, 0, 0, 0);
        wait_idle();

        // Largest register values; only automaton edits while they hold
        write_reg(dwc_pkg::CFG_WORD_LENGTH, 20'hFFFFF);
        write_reg(dwc_pkg::CFG_START_STATE, 20'hFFFFF);
        push_item(dwc_pkg::OP_LOAD, 127, 25, 127);
        push_item(dwc_pkg::OP_MARK, 64, 0, 0);
        push_item(OP_UNUSED, 0, 0, 0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pick = $urandom_range(0, 99);
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                if (pick < 70) begin
                    write_reg(dwc_pkg::CFG_WORD_LENGTH,
                              dwc_pkg::t_cfg_data'($urandom_range(0, 4)));
                end else if (pick < 95) begin
                    write_reg(dwc_pkg::CFG_WORD_LENGTH,
                              dwc_pkg::t_cfg_data'($urandom_range(5, 12)));
                end else begin
                    write_reg(dwc_pkg::CFG_WORD_LENGTH,
                              dwc_pkg::t_cfg_data'($urandom_range(13, 40)));
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                st = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 15) : $urandom_range(0, 127);
                start_val = ($urandom_range(0, 3) == 0) ? dwc_pkg::t_cfg_data'($urandom) : '0;
                start_val[dwc_pkg::STATE_FLD_W-1:0] = dwc_pkg::t_state_fld'(st);
                write_reg(dwc_pkg::CFG_START_STATE, start_val);
            end
            queue_random_items(ITEMS_PER_PHASE);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/dwc_pkg.sv
rtl/dwc_channels.sv
rtl/dfa_word_count_mod_prime_unit.sv
dv/tb_dfa_word_count_mod_prime_unit.sv
